// ----- hdl/crf_pkg.sv -----
// Shared types, constants and the CRC-32C byte update for the record frame checker.
`timescale 1ns / 1ps
`default_nettype none

package crf_pkg;

  // Record layout and format constants.
  localparam logic [7:0]  REC_VERSION      = 8'd1;
  localparam int unsigned HEADER_BYTES     = 6;
  localparam int unsigned CRC_BYTES        = 4;
  localparam int unsigned FRAME_OVERHEAD   = HEADER_BYTES + CRC_BYTES;
  localparam logic [24:0] MAX_PAYLOAD_RST  = 25'(16 * 1024 * 1024);
  localparam logic [7:0]  KIND_RST         = 8'd1;
  localparam logic [31:0] CRC32C_POLY_REF  = 32'h82F6_3B78;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REC_KIND    = 2'd0;
  localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;

  // Status codes of the end-of-record item.
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_TRUNCATED  = 2'd1;
  localparam logic [1:0] ST_BAD_HEADER = 2'd2;
  localparam logic [1:0] ST_CRC_BAD    = 2'd3;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  // Position class of a byte within the record.
  typedef enum logic [2:0] {
    CLS_VERSION,
    CLS_KIND,
    CLS_LENGTH,
    CLS_PAYLOAD,
    CLS_OTHER
  } byte_cls_t;

  // One classified item as handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    byte_cls_t  cls;
    logic       too_long;   // declared length above the configured maximum
    logic       truncated;  // final byte with fewer than ten bytes in total
    logic       len_bad;    // final byte with a total other than length plus ten
  } crf_item_t;

  // Byte-wise CRC-32C update, reflected form.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC32C_POLY_REF & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/crf_front.sv -----
// Front part: counts record bytes, assembles the length field and classifies each item.
`timescale 1ns / 1ps
`default_nettype none

module crf_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                queue_full,
  input  wire logic [7:0]          in_record_byte,
  input  wire logic                in_final_byte,
  input  wire logic [24:0]         max_payload,
  output logic                     in_stall,
  output logic                     push,
  output crf_pkg::crf_item_t       push_item
);
  import crf_pkg::*;

  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] cnt_inc;
  logic [31:0] len_shift;
  logic [32:0] payload_end;
  logic [32:0] frame_total;
  byte_cls_t   cls;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Saturating byte count, as it will stand after this byte.
  assign cnt_inc     = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
  assign len_shift   = {len_r[23:0], in_record_byte};
  assign payload_end = {1'b0, len_r} + 33'(HEADER_BYTES);
  assign frame_total = {1'b0, len_r} + 33'(FRAME_OVERHEAD);

  // Classify the byte by its position in the record.
  always_comb begin
    if (cnt_r == 32'd0) begin
      cls = CLS_VERSION;
    end else if (cnt_r == 32'd1) begin
      cls = CLS_KIND;
    end else if (cnt_r < 32'(HEADER_BYTES)) begin
      cls = CLS_LENGTH;
    end else if ({1'b0, cnt_r} < payload_end) begin
      cls = CLS_PAYLOAD;
    end else begin
      cls = CLS_OTHER;
    end
  end

  // Build the item for the queue.
  always_comb begin
    push_item.data      = in_record_byte;
    push_item.last      = in_final_byte;
    push_item.cls       = cls;
    push_item.too_long  = (cnt_r == 32'(HEADER_BYTES - 1)) &&
                          (len_shift > {7'd0, max_payload});
    push_item.truncated = cnt_inc < 32'(FRAME_OVERHEAD);
    push_item.len_bad   = {1'b0, cnt_inc} != frame_total;
  end

  // Counter and length field; both re-arm after the final byte.
  always_comb begin
    cnt_nxt = cnt_r;
    len_nxt = len_r;
    if (push) begin
      if (in_final_byte) begin
        cnt_nxt = 32'd0;
        len_nxt = 32'd0;
      end else begin
        cnt_nxt = cnt_inc;
        if (cls == CLS_LENGTH) begin
          len_nxt = len_shift;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 32'd0;
      len_r <= 32'd0;
    end else begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crf_queue.sv -----
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module crf_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire crf_pkg::crf_item_t  push_item,
  input  wire logic                pop,
  output logic                     full,
  output logic                     not_empty,
  output crf_pkg::crf_item_t       head_item
);
  import crf_pkg::*;

  crf_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]     count_r, count_nxt;

  assign full      = count_r == (QPTR_W+1)'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head_item = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/crf_back.sv -----
// Back part: header checks, CRC-32C accumulation, status decision and the output register.
`timescale 1ns / 1ps
`default_nettype none

module crf_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_avail,
  input  wire crf_pkg::crf_item_t  item,
  input  wire logic [7:0]          rec_kind,
  input  wire logic                out_stall,
  output logic                     pop,
  output logic                     out_valid,
  output logic                     out_is_status,
  output logic [7:0]               out_payload_data,
  output logic [1:0]               out_status_code
);
  import crf_pkg::*;

  logic [31:0] crc_r, crc_nxt;
  logic [31:0] trail_r, trail_nxt;
  logic        hfail_r, hfail_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        is_status_r, is_status_nxt;
  logic [7:0]  data_r, data_nxt;
  logic [1:0]  code_r, code_nxt;
  logic        slot_free;
  logic        byte_fail;
  logic [31:0] crc_upd;
  logic [31:0] trail_upd;
  logic        fail_upd;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = item_avail && slot_free;

  // Header check of this byte.
  always_comb begin
    unique case (item.cls)
      CLS_VERSION: byte_fail = item.data != REC_VERSION;
      CLS_KIND:    byte_fail = item.data != rec_kind;
      CLS_LENGTH:  byte_fail = item.too_long;
      default:     byte_fail = 1'b0;
    endcase
  end

  assign fail_upd  = hfail_r || byte_fail;
  assign trail_upd = {trail_r[23:0], item.data};
  assign crc_upd   = (item.cls == CLS_OTHER) ? crc_r : crc_byte(crc_r, item.data);

  // Record state and the result of each item taken from the queue.
  always_comb begin
    crc_nxt       = crc_r;
    trail_nxt     = trail_r;
    hfail_nxt     = hfail_r;
    out_valid_nxt = out_valid_r && out_stall;
    is_status_nxt = is_status_r;
    data_nxt      = data_r;
    code_nxt      = code_r;
    if (pop) begin
      if (item.last) begin
        crc_nxt       = 32'hFFFF_FFFF;
        trail_nxt     = 32'd0;
        hfail_nxt     = 1'b0;
        out_valid_nxt = 1'b1;
        is_status_nxt = 1'b1;
        data_nxt      = 8'd0;
        if (item.truncated) begin
          code_nxt = ST_TRUNCATED;
        end else if (fail_upd || item.len_bad) begin
          code_nxt = ST_BAD_HEADER;
        end else if (trail_upd != ~crc_upd) begin
          code_nxt = ST_CRC_BAD;
        end else begin
          code_nxt = ST_OK;
        end
      end else begin
        crc_nxt   = crc_upd;
        trail_nxt = trail_upd;
        hfail_nxt = fail_upd;
        if (item.cls == CLS_PAYLOAD && !fail_upd) begin
          out_valid_nxt = 1'b1;
          is_status_nxt = 1'b0;
          data_nxt      = item.data;
          code_nxt      = ST_OK;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r       <= 32'hFFFF_FFFF;
      trail_r     <= 32'd0;
      hfail_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      crc_r       <= crc_nxt;
      trail_r     <= trail_nxt;
      hfail_r     <= hfail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    is_status_r <= is_status_nxt;
    data_r      <= data_nxt;
    code_r      <= code_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_is_status    = is_status_r;
  assign out_payload_data = data_r;
  assign out_status_code  = code_r;

endmodule

`default_nettype wire

// ----- hdl/crc_record_frame_checker.sv -----
// Top level of the length-prefixed record checker with CRC-32C.
//
//   channel  direction  handshake           payload
//   in       input      in_valid/in_stall   in_record_byte, in_final_byte
//   out      output     out_valid/out_stall out_is_status, out_payload_data, out_status_code
//   cfg      input      cfg_we              cfg_index, cfg_data
//
// One byte item is taken per cycle while in_stall is low; each result passes the queue storage
// and then the output register. The throughput is set by the byte-wise CRC update in the back
// part, one byte a cycle. A four-item queue separates the classifying front part from the checking
// back part, so a stall on the output fills the queue first and then raises in_stall.
// Reset is synchronous and active low; no clearing pass is needed after it.
`timescale 1ns / 1ps
`default_nettype none

module crc_record_frame_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_record_byte,
  input  wire logic        in_final_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_status,
  output logic [7:0]       out_payload_data,
  output logic [1:0]       out_status_code,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [24:0] cfg_data
);
  import crf_pkg::*;

  logic [7:0]  kind_r;
  logic [24:0] max_r;
  logic        q_full;
  logic        q_not_empty;
  logic        q_push;
  logic        q_pop;
  crf_item_t   q_in_item;
  crf_item_t   q_head;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_RST;
      max_r  <= MAX_PAYLOAD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REC_KIND:    kind_r <= cfg_data[7:0];
        CFG_MAX_PAYLOAD: max_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  crf_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .queue_full     (q_full),
    .in_record_byte (in_record_byte),
    .in_final_byte  (in_final_byte),
    .max_payload    (max_r),
    .in_stall       (in_stall),
    .push           (q_push),
    .push_item      (q_in_item)
  );

  crf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_item (q_head)
  );

  crf_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .item_avail       (q_not_empty),
    .item             (q_head),
    .rec_kind         (kind_r),
    .out_stall        (out_stall),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_is_status    (out_is_status),
    .out_payload_data (out_payload_data),
    .out_status_code  (out_status_code)
  );

endmodule

`default_nettype wire
